@@ sv/eqlt_pkg.sv @@
// ----------------------------------------------------------------------------
// Escaped quoted line tokenizer package
// Shared constants, types and the escape translation function.
// ----------------------------------------------------------------------------
`default_nettype none

package eqlt_pkg;

  // Default sizes.
  localparam int unsigned TokenDepthDef = 64;
  localparam int unsigned SetSizeDef    = 8;

  // Configuration port widths.
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_DELIM_SET  = 3'd0,
    CFG_DELIM_USED = 3'd1,
    CFG_NEIGH_SET  = 3'd2,
    CFG_NEIGH_USED = 3'd3,
    CFG_SPECIAL    = 3'd4,
    CFG_MODE       = 3'd5
  } cfg_idx_e;

  // Slots of the special byte register.
  localparam int unsigned SpEscape  = 0;
  localparam int unsigned SpQuote   = 1;
  localparam int unsigned SpOpen    = 2;
  localparam int unsigned SpClose   = 3;
  localparam int unsigned SpComment = 4;

  // Mode bit positions.
  localparam int unsigned MbKeepEmpty  = 0;
  localparam int unsigned MbDropEscape = 1;
  localparam int unsigned MbDropQuote  = 2;
  localparam int unsigned MbDropParen  = 3;

  localparam logic [7:0] ChNewline = 8'h0A;

  // Parse mode, one-hot.
  typedef enum logic [6:0] {
    PM_NORMAL  = 7'b0000001,
    PM_ESC     = 7'b0000010,
    PM_QUOTE   = 7'b0000100,
    PM_QESC    = 7'b0001000,
    PM_PAREN   = 7'b0010000,
    PM_PESC    = 7'b0100000,
    PM_COMMENT = 7'b1000000
  } parse_mode_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;   // take the input item
    logic rd;       // issue a token store read at the emit index
    logic load;     // capture the read data into the result register
    logic advance;  // result transferred, step the emit index
    logic post;     // write the pending comment byte as a new token
  } eqlt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic fin;       // the offered item ends a token
    logic nonempty;  // the token being ended has bytes after trimming
    logic keep;      // empty tokens are emitted
    logic comment;   // the offered item opens a comment
    logic last;      // the held result is the last of its token
    logic pend;      // a comment byte waits to be stored
  } eqlt_status_t;

  // C escape translation.
  function automatic logic [7:0] esc_xlate(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    case (b)
      8'h6E:   r = 8'h0A;  // n
      8'h74:   r = 8'h09;  // t
      8'h76:   r = 8'h0B;  // v
      8'h62:   r = 8'h08;  // b
      8'h72:   r = 8'h0D;  // r
      8'h66:   r = 8'h0C;  // f
      8'h61:   r = 8'h07;  // a
      default: r = b;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ sv/eqlt_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module eqlt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64,
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ sv/eqlt_datapath.sv @@
// ----------------------------------------------------------------------------
// Tokenizer datapath
// Configuration registers, parse state, token store and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module eqlt_datapath import eqlt_pkg::*; #(
  parameter int unsigned TOKEN_DEPTH = TokenDepthDef,
  parameter int unsigned SET_SIZE    = SetSizeDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                req_type_i,
  input  wire logic [7:0]          in_byte_i,
  input  wire eqlt_cmd_t           cmd_i,
  output eqlt_status_t             status_o,
  output logic [7:0]               out_byte_o,
  output logic                     has_byte_o,
  output logic                     token_end_o,
  output logic                     token_quoted_o,
  output logic                     token_truncated_o
);

  localparam int unsigned AW = $clog2(TOKEN_DEPTH);
  localparam int unsigned LW = $clog2(TOKEN_DEPTH + 1);

  // Configuration registers.
  logic [63:0] delim_set_q, neigh_set_q;
  logic [3:0]  delim_used_q, neigh_used_q, mode_cfg_q;
  logic [39:0] special_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_set_q  <= '0;
      delim_used_q <= '0;
      neigh_set_q  <= '0;
      neigh_used_q <= '0;
      special_q    <= '0;
      mode_cfg_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DELIM_SET:  delim_set_q  <= cfg_wdata_i;
        CFG_DELIM_USED: delim_used_q <= cfg_wdata_i[3:0];
        CFG_NEIGH_SET:  neigh_set_q  <= cfg_wdata_i;
        CFG_NEIGH_USED: neigh_used_q <= cfg_wdata_i[3:0];
        CFG_SPECIAL:    special_q    <= cfg_wdata_i[39:0];
        CFG_MODE:       mode_cfg_q   <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  // Token state.
  parse_mode_e   mode_q, mode_d;
  logic [LW-1:0] len_q, trail_q;
  logic          quoted_q, ovf_q;
  logic [LW-1:0] emit_len_q;
  logic          emit_quoted_q, emit_ovf_q;
  logic [AW-1:0] idx_q;
  logic          pend_q;
  logic [7:0]    pend_byte_q;

  // Class of the offered byte.
  logic [4:0] sp;
  logic       is_delim, is_neigh;

  always_comb begin
    is_delim = 1'b0;
    is_neigh = 1'b0;
    for (int k = 0; k < SET_SIZE; k++) begin
      if (4'(k) < delim_used_q && delim_set_q[8*k +: 8] == in_byte_i) is_delim = 1'b1;
      if (4'(k) < neigh_used_q && neigh_set_q[8*k +: 8] == in_byte_i) is_neigh = 1'b1;
    end
    for (int s = 0; s < 5; s++) begin
      sp[s] = (special_q[8*s +: 8] != 8'h00) && (special_q[8*s +: 8] == in_byte_i);
    end
  end

  // Parse step for the offered item.
  logic       do_put, do_plain, do_neigh, set_quoted, fin, comment;
  logic [7:0] wbyte;

  always_comb begin
    do_put     = 1'b0;
    do_plain   = 1'b0;
    do_neigh   = 1'b0;
    set_quoted = 1'b0;
    fin        = 1'b0;
    comment    = 1'b0;
    wbyte      = in_byte_i;
    mode_d     = mode_q;
    if (req_type_i) begin
      fin    = 1'b1;
      mode_d = PM_NORMAL;
    end else begin
      case (mode_q)
        PM_ESC: begin
          do_put   = 1'b1;
          do_plain = 1'b1;
          wbyte    = mode_cfg_q[MbDropEscape] ? esc_xlate(in_byte_i) : in_byte_i;
          mode_d   = PM_NORMAL;
        end
        PM_QUOTE: begin
          if (sp[SpQuote]) begin
            mode_d   = PM_NORMAL;
            do_put   = !mode_cfg_q[MbDropQuote];
            do_plain = do_put;
          end else if (sp[SpEscape]) begin
            mode_d = PM_QESC;
          end else begin
            do_put   = 1'b1;
            do_plain = 1'b1;
          end
        end
        PM_QESC: begin
          do_put   = 1'b1;
          do_plain = 1'b1;
          wbyte    = esc_xlate(in_byte_i);
          mode_d   = PM_QUOTE;
        end
        PM_PAREN: begin
          if (sp[SpClose]) begin
            mode_d   = PM_NORMAL;
            do_put   = !mode_cfg_q[MbDropParen];
            do_plain = do_put;
          end else if (sp[SpEscape]) begin
            mode_d = PM_PESC;
          end else begin
            do_put   = 1'b1;
            do_plain = 1'b1;
          end
        end
        PM_PESC: begin
          do_put   = 1'b1;
          do_plain = 1'b1;
          wbyte    = esc_xlate(in_byte_i);
          mode_d   = PM_PAREN;
        end
        PM_COMMENT: begin
          if (in_byte_i == ChNewline) begin
            fin    = 1'b1;
            mode_d = PM_NORMAL;
          end else begin
            do_put   = 1'b1;
            do_plain = 1'b1;
          end
        end
        default: begin
          mode_d = PM_NORMAL;
          if (sp[SpEscape]) begin
            mode_d   = PM_ESC;
            do_put   = !mode_cfg_q[MbDropEscape];
            do_plain = do_put;
          end else if (sp[SpQuote]) begin
            mode_d     = PM_QUOTE;
            set_quoted = 1'b1;
            do_put     = !mode_cfg_q[MbDropQuote];
            do_plain   = do_put;
          end else if (sp[SpOpen]) begin
            mode_d     = PM_PAREN;
            set_quoted = 1'b1;
            do_put     = !mode_cfg_q[MbDropParen];
            do_plain   = do_put;
          end else if (sp[SpComment]) begin
            fin     = 1'b1;
            comment = 1'b1;
            mode_d  = PM_COMMENT;
          end else if (is_delim) begin
            fin = 1'b1;
          end else if (is_neigh) begin
            if (len_q != '0) begin
              do_put   = 1'b1;
              do_neigh = 1'b1;
            end
          end else begin
            do_put   = 1'b1;
            do_plain = 1'b1;
          end
        end
      endcase
    end
  end

  // Token store write.
  logic          room;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;

  assign room      = len_q < LW'(TOKEN_DEPTH);
  assign ram_we    = (cmd_i.accept && !fin && do_put && room) || cmd_i.post;
  assign ram_waddr = cmd_i.post ? '0 : len_q[AW-1:0];
  assign ram_wdata = cmd_i.post ? pend_byte_q : wbyte;

  eqlt_ram #(
    .Width (8),
    .Depth (TOKEN_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.rd),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  // Parse state and emission bookkeeping.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= PM_NORMAL;
      len_q         <= '0;
      trail_q       <= '0;
      quoted_q      <= 1'b0;
      ovf_q         <= 1'b0;
      emit_len_q    <= '0;
      emit_quoted_q <= 1'b0;
      emit_ovf_q    <= 1'b0;
      idx_q         <= '0;
      pend_q        <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        mode_q <= mode_d;
        idx_q  <= '0;
        if (fin) begin
          emit_len_q    <= len_q - trail_q;
          emit_quoted_q <= quoted_q;
          emit_ovf_q    <= ovf_q;
          len_q         <= '0;
          trail_q       <= '0;
          quoted_q      <= 1'b0;
          ovf_q         <= 1'b0;
          pend_q        <= comment;
        end else begin
          if (set_quoted) quoted_q <= 1'b1;
          if (do_put) begin
            if (room) len_q <= len_q + LW'(1);
            else      ovf_q <= 1'b1;
          end
          if (do_plain) begin
            trail_q <= '0;
          end else if (do_neigh && room) begin
            trail_q <= trail_q + LW'(1);
          end
        end
      end
      if (cmd_i.advance) begin
        idx_q <= idx_q + AW'(1);
      end
      if (cmd_i.post) begin
        len_q  <= LW'(1);
        pend_q <= 1'b0;
      end
    end
  end

  // Pending comment byte.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      pend_byte_q <= in_byte_i;
    end
  end

  // Result register.
  logic empty_tok;
  assign empty_tok = (emit_len_q == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_byte_o        <= empty_tok ? 8'h00 : ram_rdata;
      has_byte_o        <= !empty_tok;
      token_end_o       <= empty_tok || (LW'(idx_q) + LW'(1) == emit_len_q);
      token_quoted_o    <= emit_quoted_q;
      token_truncated_o <= emit_ovf_q;
    end
  end

  assign status_o.fin      = fin;
  assign status_o.nonempty = (len_q != trail_q);
  assign status_o.keep     = mode_cfg_q[MbKeepEmpty];
  assign status_o.comment  = comment;
  assign status_o.last     = token_end_o;
  assign status_o.pend     = pend_q;

endmodule

`default_nettype wire

@@ sv/eqlt_ctrl.sv @@
// ----------------------------------------------------------------------------
// Tokenizer controller
// Sequences item acceptance, token store reads and result transfers.
// ----------------------------------------------------------------------------
`default_nettype none

module eqlt_ctrl import eqlt_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  input  wire eqlt_status_t status_i,
  output eqlt_cmd_t         cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_RD   = 5'b00010,
    ST_LOAD = 5'b00100,
    ST_SEND = 5'b01000,
    ST_POST = 5'b10000
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (status_i.fin) begin
            if (status_i.nonempty)     state_d = ST_RD;
            else if (status_i.keep)    state_d = ST_LOAD;
            else if (status_i.comment) state_d = ST_POST;
          end
        end
      end
      ST_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_LOAD;
      end
      ST_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = ST_SEND;
      end
      ST_SEND: begin
        if (out_ready_i) begin
          cmd_o.advance = 1'b1;
          if (!status_i.last)    state_d = ST_RD;
          else if (status_i.pend) state_d = ST_POST;
          else                    state_d = ST_IDLE;
        end
      end
      ST_POST: begin
        cmd_o.post = 1'b1;
        state_d    = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_SEND);

endmodule

`default_nettype wire

@@ sv/escaped_quoted_line_tokenizer.sv @@
// ----------------------------------------------------------------------------
// Escaped quoted line tokenizer
// Splits a byte stream into tokens with quotes, brackets, escapes and
// comments, and emits finished tokens byte by byte, empty ones only if kept.
//
// Channel  Direction  Handshake                  Payload
// in       input      in_valid_i / in_ready_o    req_type_i, in_byte_i
// out      output     out_valid_o / out_ready_i  out_byte_o .. run_last_o
// cfg      input      cfg_we_i                   cfg_idx_i, cfg_wdata_i
//
// A byte that ends no token leaves the block ready for the next item.
// Each token byte is read from the token store in the steps read, load
// and transfer, which waits for out_ready_i; a kept empty token skips the read.
// A comment byte that opens a new token is stored once the token before it is emitted.
// Reset clears the parse state; the token store needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module escaped_quoted_line_tokenizer import eqlt_pkg::*; #(
  parameter int unsigned TOKEN_DEPTH = TokenDepthDef,
  parameter int unsigned SET_SIZE    = SetSizeDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic                req_type_i,
  input  wire logic [7:0]          in_byte_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [7:0]               out_byte_o,
  output logic                     has_byte_o,
  output logic                     token_end_o,
  output logic                     token_quoted_o,
  output logic                     token_truncated_o,
  output logic                     run_last_o
);

  eqlt_cmd_t    cmd;
  eqlt_status_t status;

  eqlt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  eqlt_datapath #(
    .TOKEN_DEPTH (TOKEN_DEPTH),
    .SET_SIZE    (SET_SIZE)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .req_type_i        (req_type_i),
    .in_byte_i         (in_byte_i),
    .cmd_i             (cmd),
    .status_o          (status),
    .out_byte_o        (out_byte_o),
    .has_byte_o        (has_byte_o),
    .token_end_o       (token_end_o),
    .token_quoted_o    (token_quoted_o),
    .token_truncated_o (token_truncated_o)
  );

  // At most one token ends per item, so its last byte closes the run.
  assign run_last_o = token_end_o;

`ifndef NO_ASSERTIONS
  // Items are not taken while a result is held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input taken while a result is pending");

  // A byteless result is always a whole token.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !has_byte_o) |-> token_end_o)
    else $error("byteless result not at token end");

  // After the last transfer of a token no result follows at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && token_end_o) |=> !out_valid_o)
    else $error("result follows the end of a token");
`endif

endmodule

`default_nettype wire
